>>> hw/rtl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// shared constants and types for the collinear segment merge block
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam int COORD_BITS = 12;

  localparam int CFG_AW = 8;
  localparam int CFG_DW = 16;

  localparam int COS_W  = 16;
  localparam int DIST_W = 12;
  localparam int LEN_W  = 8;
  localparam int Q_BITS = 15;

  localparam logic [COS_W-1:0]  MIN_COS_RST  = COS_W'(31457);
  localparam logic [DIST_W-1:0] MAX_LINE_RST = DIST_W'(30);
  localparam logic [DIST_W-1:0] MAX_GAP_RST  = DIST_W'(60);
  localparam logic [LEN_W-1:0]  MIN_LEN_RST  = LEN_W'(1);

  typedef enum logic [CFG_AW-1:0] {
    REG_MIN_COS    = CFG_AW'(0),
    REG_MAX_LINE   = CFG_AW'(1),
    REG_MAX_GAP    = CFG_AW'(2),
    REG_MIN_LENGTH = CFG_AW'(3)
  } cfg_reg_e;

  // squared thresholds as the datapath uses them
  typedef struct packed {
    logic [2*COS_W-1:0]  cos2;
    logic [2*DIST_W-1:0] line2;
    logic [2*DIST_W-1:0] gap2;
    logic [2*LEN_W-1:0]  len2;
  } cfg_t;

endpackage

>>> hw/rtl/csm_cfg.sv
// ----------------------------------------------------------------------------
// csm_cfg
// configuration registers and their registered squares
// ----------------------------------------------------------------------------
module csm_cfg
  import csm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output cfg_t              cfg_o
);

  logic [COS_W-1:0]  min_cos_q;
  logic [DIST_W-1:0] max_line_q;
  logic [DIST_W-1:0] max_gap_q;
  logic [LEN_W-1:0]  min_len_q;
  cfg_t              sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cos_q  <= MIN_COS_RST;
      max_line_q <= MAX_LINE_RST;
      max_gap_q  <= MAX_GAP_RST;
      min_len_q  <= MIN_LEN_RST;
      sq_q.cos2  <= (2*COS_W)'(MIN_COS_RST) * (2*COS_W)'(MIN_COS_RST);
      sq_q.line2 <= (2*DIST_W)'(MAX_LINE_RST) * (2*DIST_W)'(MAX_LINE_RST);
      sq_q.gap2  <= (2*DIST_W)'(MAX_GAP_RST) * (2*DIST_W)'(MAX_GAP_RST);
      sq_q.len2  <= (2*LEN_W)'(MIN_LEN_RST) * (2*LEN_W)'(MIN_LEN_RST);
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          REG_MIN_COS:    min_cos_q  <= cfg_data_i[COS_W-1:0];
          REG_MAX_LINE:   max_line_q <= cfg_data_i[DIST_W-1:0];
          REG_MAX_GAP:    max_gap_q  <= cfg_data_i[DIST_W-1:0];
          REG_MIN_LENGTH: min_len_q  <= cfg_data_i[LEN_W-1:0];
          default:        ;
        endcase
      end
      sq_q.cos2  <= (2*COS_W)'(min_cos_q) * (2*COS_W)'(min_cos_q);
      sq_q.line2 <= (2*DIST_W)'(max_line_q) * (2*DIST_W)'(max_line_q);
      sq_q.gap2  <= (2*DIST_W)'(max_gap_q) * (2*DIST_W)'(max_gap_q);
      sq_q.len2  <= (2*LEN_W)'(min_len_q) * (2*LEN_W)'(min_len_q);
    end
  end

  assign cfg_o = sq_q;

endmodule

>>> hw/rtl/collinear_segment_merge.sv
// ----------------------------------------------------------------------------
// collinear_segment_merge
// five-stage pipeline testing two segments for a merge and giving the
// farthest endpoint pair of a merged pair
// ----------------------------------------------------------------------------
// channel   signals                               moves
// in        in_valid_i / in_ready_o               one segment pair request
// out       out_valid_o / out_ready_i             one merge decision
// cfg       cfg_valid_i / cfg_ready_o             one register write request
//
// one request per cycle sustained while the output is taken; an accepted request
// moves through the input, squares, products, wide products and compare stages
// reset clears all stage valid bits and loads the register defaults
// a stage holds only while the one after it is full and held, so bubbles close up
// cfg_ready_o is always high
// ----------------------------------------------------------------------------
module collinear_segment_merge
  import csm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] a_x0_i,
  input  logic [COORD_BITS-1:0] a_y0_i,
  input  logic [COORD_BITS-1:0] a_x1_i,
  input  logic [COORD_BITS-1:0] a_y1_i,
  input  logic [COORD_BITS-1:0] b_x0_i,
  input  logic [COORD_BITS-1:0] b_y0_i,
  input  logic [COORD_BITS-1:0] b_x1_i,
  input  logic [COORD_BITS-1:0] b_y1_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  do_merge_o,
  output logic [COORD_BITS-1:0] merged_x0_o,
  output logic [COORD_BITS-1:0] merged_y0_o,
  output logic [COORD_BITS-1:0] merged_x1_o,
  output logic [COORD_BITS-1:0] merged_y1_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_AW-1:0]     cfg_addr_i,
  input  logic [CFG_DW-1:0]     cfg_data_i
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;
  localparam int SQW   = 2 * CW + 1;
  localparam int SW    = CW + 2;
  localparam int PRW   = DW + SW;
  localparam int CRW   = PRW + 1;
  localparam int DOTW  = 2 * DW + 1;
  localparam int PW    = 2 * SQW;
  localparam int CS2W  = 2 * COS_W;
  localparam int HW    = SQW + CS2W;
  localparam int RHSW  = PW + CS2W;
  localparam int Q2SH  = 2 * Q_BITS;
  localparam int DRW   = 2 * DIST_W + SQW;
  localparam int CR2W  = 2 * CRW;
  localparam int DCW   = (CR2W > DRW + 2) ? CR2W : DRW + 2;
  localparam int GW    = (SQW > 2 * DIST_W) ? SQW : 2 * DIST_W;
  localparam int LW    = (SQW > 2 * LEN_W) ? SQW : 2 * LEN_W;

  typedef logic [3:0][CW-1:0] pts_t;

  typedef struct packed {
    logic [SQW-1:0] d;
    logic [1:0]     pi;
    logic [1:0]     pj;
  } cand_t;

  function automatic logic [SQW-1:0] dist_sq(input logic [CW-1:0] xa, input logic [CW-1:0] ya,
                                             input logic [CW-1:0] xb, input logic [CW-1:0] yb);
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic signed [2*DW-1:0] qx;
    logic signed [2*DW-1:0] qy;
    dx = $signed({1'b0, xa}) - $signed({1'b0, xb});
    dy = $signed({1'b0, ya}) - $signed({1'b0, yb});
    qx = dx * dx;
    qy = dy * dy;
    return SQW'(qx) + SQW'(qy);
  endfunction

  // later candidate wins only when strictly farther
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.d > a.d) ? b : a;
  endfunction

  cfg_t cfg;

  csm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // stage valids and enables
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic en0, en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_ready_o = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 0: input capture
  pts_t s0_px_q, s0_py_q;

  // stage 1: differences and squares
  logic signed [DW-1:0]   dax, day, dbx, dby;
  logic signed [SW-1:0]   sx, sy;
  logic signed [DOTW-1:0] dot_d;
  logic signed [PRW-1:0]  pa_d, pb_d;

  assign dax = $signed({1'b0, s0_px_q[1]}) - $signed({1'b0, s0_px_q[0]});
  assign day = $signed({1'b0, s0_py_q[1]}) - $signed({1'b0, s0_py_q[0]});
  assign dbx = $signed({1'b0, s0_px_q[3]}) - $signed({1'b0, s0_px_q[2]});
  assign dby = $signed({1'b0, s0_py_q[3]}) - $signed({1'b0, s0_py_q[2]});
  assign sx  = $signed({2'b00, s0_px_q[0]}) + $signed({2'b00, s0_px_q[1]})
             - $signed({1'b0, s0_px_q[2], 1'b0});
  assign sy  = $signed({2'b00, s0_py_q[0]}) + $signed({2'b00, s0_py_q[1]})
             - $signed({1'b0, s0_py_q[2], 1'b0});
  assign dot_d = DOTW'(dax * dbx) + DOTW'(day * dby);
  assign pa_d  = PRW'(dby * sx);
  assign pb_d  = PRW'(dbx * sy);

  pts_t                   s1_px_q, s1_py_q;
  logic [SQW-1:0]         la_q, lb_q, d02_q, d03_q, d12_q, d13_q;
  logic signed [DOTW-1:0] dot_q;
  logic signed [PRW-1:0]  pa_q, pb_q;

  // stage 2: products, cross term, gap minimum, first pair round
  logic [PW-1:0]         prod_d;
  logic [SQW-1:0]        dmag_d;
  logic signed [CRW-1:0] cross_d;
  logic [DRW-1:0]        dr_d;
  logic [SQW-1:0]        gm_a, gm_b, gmin_d;
  logic                  len_fail_d;
  cand_t                 f0_d, f1_d, f2_d;

  assign prod_d  = PW'(la_q) * PW'(lb_q);
  assign dmag_d  = dot_q[DOTW-1] ? SQW'(-dot_q) : SQW'(dot_q);
  assign cross_d = CRW'(pa_q) - CRW'(pb_q);
  assign dr_d    = DRW'(cfg.line2) * DRW'(lb_q);
  assign gm_a    = (d03_q < d02_q) ? d03_q : d02_q;
  assign gm_b    = (d13_q < d12_q) ? d13_q : d12_q;
  assign gmin_d  = (gm_b < gm_a) ? gm_b : gm_a;
  assign len_fail_d = (LW'(la_q) < LW'(cfg.len2)) || (LW'(lb_q) < LW'(cfg.len2));
  assign f0_d = pick('{d: la_q,  pi: 2'd0, pj: 2'd1}, '{d: d02_q, pi: 2'd0, pj: 2'd2});
  assign f1_d = pick('{d: d03_q, pi: 2'd0, pj: 2'd3}, '{d: d12_q, pi: 2'd1, pj: 2'd2});
  assign f2_d = pick('{d: d13_q, pi: 2'd1, pj: 2'd3}, '{d: lb_q,  pi: 2'd2, pj: 2'd3});

  pts_t                  s2_px_q, s2_py_q;
  logic [PW-1:0]         prod_q;
  logic [SQW-1:0]        dmag_q, gmin_q;
  logic signed [CRW-1:0] cross_q;
  logic [DRW-1:0]        s2_dr_q;
  logic                  s2_len_fail_q, s2_lb_zero_q;
  cand_t                 f0_q, f1_q, f2_q;

  // stage 3: split angle product, squares, gap test, final pair rounds
  logic [HW-1:0]   ph_d, pl_d;
  logic [PW-1:0]   dot2_d;
  logic [CR2W-1:0] cross2_d;
  logic            gap_fail_d;
  cand_t           best_d;

  assign ph_d       = HW'(prod_q[PW-1:SQW]) * HW'(cfg.cos2);
  assign pl_d       = HW'(prod_q[SQW-1:0]) * HW'(cfg.cos2);
  assign dot2_d     = PW'(dmag_q) * PW'(dmag_q);
  assign cross2_d   = CR2W'(cross_q * cross_q);
  assign gap_fail_d = GW'(gmin_q) > GW'(cfg.gap2);
  assign best_d     = pick(pick(f0_q, f1_q), f2_q);

  pts_t            s3_px_q, s3_py_q;
  logic [HW-1:0]   ph_q, pl_q;
  logic [PW-1:0]   dot2_q;
  logic [CR2W-1:0] cross2_q;
  logic [DRW-1:0]  s3_dr_q;
  logic            s3_len_fail_q, s3_lb_zero_q, s3_gap_fail_q;
  cand_t           best_q;

  // stage 4: wide compares and result select
  logic [RHSW-1:0] rhs, lhs;
  logic            angle_fail, dist_fail, ok;

  assign rhs        = (RHSW'(ph_q) << SQW) + RHSW'(pl_q);
  assign lhs        = RHSW'(dot2_q) << Q2SH;
  assign angle_fail = lhs < rhs;
  assign dist_fail  = DCW'(cross2_q) > (DCW'(s3_dr_q) << 2);
  assign ok = !s3_len_fail_q && !s3_lb_zero_q && !s3_gap_fail_q && !angle_fail && !dist_fail;

  logic          do_merge_q;
  logic [CW-1:0] mx0_q, my0_q, mx1_q, my1_q;

  always_ff @(posedge clk_i) begin
    if (en0) begin
      s0_px_q <= {b_x1_i, b_x0_i, a_x1_i, a_x0_i};
      s0_py_q <= {b_y1_i, b_y0_i, a_y1_i, a_y0_i};
    end
    if (en1) begin
      s1_px_q <= s0_px_q;
      s1_py_q <= s0_py_q;
      la_q    <= dist_sq(s0_px_q[1], s0_py_q[1], s0_px_q[0], s0_py_q[0]);
      lb_q    <= dist_sq(s0_px_q[3], s0_py_q[3], s0_px_q[2], s0_py_q[2]);
      d02_q   <= dist_sq(s0_px_q[0], s0_py_q[0], s0_px_q[2], s0_py_q[2]);
      d03_q   <= dist_sq(s0_px_q[0], s0_py_q[0], s0_px_q[3], s0_py_q[3]);
      d12_q   <= dist_sq(s0_px_q[1], s0_py_q[1], s0_px_q[2], s0_py_q[2]);
      d13_q   <= dist_sq(s0_px_q[1], s0_py_q[1], s0_px_q[3], s0_py_q[3]);
      dot_q   <= dot_d;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
    end
    if (en2) begin
      s2_px_q       <= s1_px_q;
      s2_py_q       <= s1_py_q;
      prod_q        <= prod_d;
      dmag_q        <= dmag_d;
      cross_q       <= cross_d;
      s2_dr_q       <= dr_d;
      gmin_q        <= gmin_d;
      s2_len_fail_q <= len_fail_d;
      s2_lb_zero_q  <= (lb_q == '0);
      f0_q          <= f0_d;
      f1_q          <= f1_d;
      f2_q          <= f2_d;
    end
    if (en3) begin
      s3_px_q       <= s2_px_q;
      s3_py_q       <= s2_py_q;
      ph_q          <= ph_d;
      pl_q          <= pl_d;
      dot2_q        <= dot2_d;
      cross2_q      <= cross2_d;
      s3_dr_q       <= s2_dr_q;
      s3_len_fail_q <= s2_len_fail_q;
      s3_lb_zero_q  <= s2_lb_zero_q;
      s3_gap_fail_q <= gap_fail_d;
      best_q        <= best_d;
    end
    if (en4) begin
      do_merge_q <= ok;
      mx0_q      <= ok ? s3_px_q[best_q.pi] : '0;
      my0_q      <= ok ? s3_py_q[best_q.pi] : '0;
      mx1_q      <= ok ? s3_px_q[best_q.pj] : '0;
      my1_q      <= ok ? s3_py_q[best_q.pj] : '0;
    end
  end

  assign out_valid_o = v4_q;
  assign do_merge_o  = do_merge_q;
  assign merged_x0_o = mx0_q;
  assign merged_y0_o = my0_q;
  assign merged_x1_o = mx1_q;
  assign merged_y1_o = my1_q;

  // rejected pairs carry zero endpoints
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !do_merge_o |-> merged_x0_o == '0 && merged_y0_o == '0 &&
                                   merged_x1_o == '0 && merged_y1_o == '0)
    else $error("rejected pair with nonzero endpoints");

  // input only stalls when the output holds a result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // taken result with nothing behind it empties the output
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !v3_q |=> !out_valid_o)
    else $error("output valid without a request behind it");

endmodule

>>> tb/collinear_segment_merge_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collinear_segment_merge_test
// self-checking bench for the segment merge block: each accepted segment pair
// is scored by a local model of the length, angle, line distance and gap
// tests and the farthest endpoint pair, and every merge decision is compared
// field by field; directed corner pairs come first, then collinear-biased
// random pairs under several register settings and idle/stall patterns
// ----------------------------------------------------------------------------
module collinear_segment_merge_test;
  import csm_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int PIPE_DEPTH = 5;
  localparam int CYCLE_LIMIT = 300000;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int PAIRS_PER_SET = 92;
  localparam logic [CFG_AW-1:0] REG_UNUSED_LO = CFG_AW'(4);
  localparam logic [CFG_AW-1:0] REG_UNUSED_HI = CFG_AW'(255);

  // index 0 = A start, 1 = A end, 2 = B start, 3 = B end
  typedef struct packed {
    logic [3:0][COORD_BITS-1:0] x;
    logic [3:0][COORD_BITS-1:0] y;
  } seg_pair_t;

  typedef struct packed {
    logic                  do_merge;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
  } merge_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [COORD_BITS-1:0] a_x0_i = '0;
  logic [COORD_BITS-1:0] a_y0_i = '0;
  logic [COORD_BITS-1:0] a_x1_i = '0;
  logic [COORD_BITS-1:0] a_y1_i = '0;
  logic [COORD_BITS-1:0] b_x0_i = '0;
  logic [COORD_BITS-1:0] b_y0_i = '0;
  logic [COORD_BITS-1:0] b_x1_i = '0;
  logic [COORD_BITS-1:0] b_y1_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  do_merge_o;
  logic [COORD_BITS-1:0] merged_x0_o;
  logic [COORD_BITS-1:0] merged_y0_o;
  logic [COORD_BITS-1:0] merged_x1_o;
  logic [COORD_BITS-1:0] merged_y1_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_AW-1:0]     cfg_addr_i = '0;
  logic [CFG_DW-1:0]     cfg_data_i = '0;

  logic [COS_W-1:0]  lim_cos = MIN_COS_RST;
  logic [DIST_W-1:0] lim_line = MAX_LINE_RST;
  logic [DIST_W-1:0] lim_gap = MAX_GAP_RST;
  logic [LEN_W-1:0]  lim_len = MIN_LEN_RST;

  merge_res_t  merge_expect_q[$];
  merge_res_t  want_res;
  int          fail_count = 0;
  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  collinear_segment_merge dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_x0_i      (a_x0_i),
    .a_y0_i      (a_y0_i),
    .a_x1_i      (a_x1_i),
    .a_y1_i      (a_y1_i),
    .b_x0_i      (b_x0_i),
    .b_y0_i      (b_y0_i),
    .b_x1_i      (b_x1_i),
    .b_y1_i      (b_y1_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .do_merge_o  (do_merge_o),
    .merged_x0_o (merged_x0_o),
    .merged_y0_o (merged_y0_o),
    .merged_x1_o (merged_x1_o),
    .merged_y1_o (merged_y1_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic longint sq_dist(longint xa, longint ya, longint xb, longint yb);
    return (xa - xb) * (xa - xb) + (ya - yb) * (ya - yb);
  endfunction

  function automatic merge_res_t predict_merge(seg_pair_t p);
    longint     px[4];
    longint     py[4];
    longint     dax, day, dbx, dby, len_a, len_b, min_len2;
    longint     dot, cross_v, gap, best, d2;
    logic [127:0] dot_term, cos_term, cross_term, line_term;
    int         bi, bj;
    bit         ok;
    merge_res_t res;
    for (int k = 0; k < 4; k++) begin
      px[k] = longint'(p.x[k]);
      py[k] = longint'(p.y[k]);
    end
    dax = px[1] - px[0];
    day = py[1] - py[0];
    dbx = px[3] - px[2];
    dby = py[3] - py[2];
    len_a = dax * dax + day * day;
    len_b = dbx * dbx + dby * dby;
    min_len2 = longint'(lim_len) * longint'(lim_len);
    ok = (len_a >= min_len2) && (len_b >= min_len2);
    // angle: (|dA.dB| << 15)^2 against cos^2 * LA * LB
    if (ok) begin
      dot = dax * dbx + day * dby;
      if (dot < 0) dot = -dot;
      dot_term = 128'(dot) << Q_BITS;
      dot_term = dot_term * dot_term;
      cos_term = 128'(len_a) * 128'(len_b) * 128'(lim_cos) * 128'(lim_cos);
      if (dot_term < cos_term) ok = 1'b0;
    end
    if (ok && len_b == 0) ok = 1'b0;
    // midpoint of A against the line of B, both sides scaled by 2
    if (ok) begin
      cross_v = dby * (px[0] + px[1] - 2 * px[2]) - dbx * (py[0] + py[1] - 2 * py[2]);
      if (cross_v < 0) cross_v = -cross_v;
      cross_term = 128'(cross_v) * 128'(cross_v);
      line_term = 128'(4) * 128'(lim_line) * 128'(lim_line) * 128'(len_b);
      if (cross_term > line_term) ok = 1'b0;
    end
    if (ok) begin
      gap = sq_dist(px[0], py[0], px[2], py[2]);
      d2 = sq_dist(px[0], py[0], px[3], py[3]);
      if (d2 < gap) gap = d2;
      d2 = sq_dist(px[1], py[1], px[2], py[2]);
      if (d2 < gap) gap = d2;
      d2 = sq_dist(px[1], py[1], px[3], py[3]);
      if (d2 < gap) gap = d2;
      if (gap > longint'(lim_gap) * longint'(lim_gap)) ok = 1'b0;
    end
    res = '0;
    if (ok) begin
      bi = 0;
      bj = 1;
      best = sq_dist(px[0], py[0], px[1], py[1]);
      // ties keep the earlier pair
      for (int i = 0; i < 4; i++) begin
        for (int j = i + 1; j < 4; j++) begin
          d2 = sq_dist(px[i], py[i], px[j], py[j]);
          if (d2 > best) begin
            best = d2;
            bi = i;
            bj = j;
          end
        end
      end
      res.do_merge = 1'b1;
      res.x0 = p.x[bi];
      res.y0 = p.y[bi];
      res.x1 = p.x[bj];
      res.y1 = p.y[bj];
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (merge_expect_q.size() == 0) begin
        $error("merge result with no request pending: do_merge %0d", do_merge_o);
        fail_count++;
      end else begin
        want_res = merge_expect_q.pop_front();
        if (do_merge_o !== want_res.do_merge) begin
          $error("do_merge: expected %0d, got %0d", want_res.do_merge, do_merge_o);
          fail_count++;
        end
        if (merged_x0_o !== want_res.x0) begin
          $error("merged_x0: expected %0d, got %0d", want_res.x0, merged_x0_o);
          fail_count++;
        end
        if (merged_y0_o !== want_res.y0) begin
          $error("merged_y0: expected %0d, got %0d", want_res.y0, merged_y0_o);
          fail_count++;
        end
        if (merged_x1_o !== want_res.x1) begin
          $error("merged_x1: expected %0d, got %0d", want_res.x1, merged_x1_o);
          fail_count++;
        end
        if (merged_y1_o !== want_res.y1) begin
          $error("merged_y1: expected %0d, got %0d", want_res.y1, merged_y1_o);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    return COORD_BITS'(v);
  endfunction

  function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.x[0] = clamp_coord(ax0);
    p.y[0] = clamp_coord(ay0);
    p.x[1] = clamp_coord(ax1);
    p.y[1] = clamp_coord(ay1);
    p.x[2] = clamp_coord(bx0);
    p.y[2] = clamp_coord(by0);
    p.x[3] = clamp_coord(bx1);
    p.y[3] = clamp_coord(by1);
    return p;
  endfunction

  // B continues or overlaps A along the same direction, with jitter
  function automatic seg_pair_t gen_collinear_pair();
    int x0, y0, dx, dy, s, k, jit, bx0, by0;
    seg_pair_t p;
    seg_pair_t q;
    x0 = $urandom_range(COORD_MAX);
    y0 = $urandom_range(COORD_MAX);
    dx = int'($urandom_range(600)) - 300;
    dy = int'($urandom_range(600)) - 300;
    if (dx == 0 && dy == 0) dx = 1;
    jit = ($urandom_range(7) == 0) ? 60 : 6;
    s = int'($urandom_range(20)) - 14;
    k = $urandom_range(1, 16);
    bx0 = x0 + dx + dx * s / 8 + int'($urandom_range(2 * jit)) - jit;
    by0 = y0 + dy + dy * s / 8 + int'($urandom_range(2 * jit)) - jit;
    p = make_pair(x0, y0, x0 + dx, y0 + dy, bx0, by0,
                  bx0 + dx * k / 8 + int'($urandom_range(2 * jit)) - jit,
                  by0 + dy * k / 8 + int'($urandom_range(2 * jit)) - jit);
    q = p;
    if ($urandom_range(1)) begin
      q.x[0] = p.x[1]; q.y[0] = p.y[1]; q.x[1] = p.x[0]; q.y[1] = p.y[0];
    end
    if ($urandom_range(1)) begin
      q.x[2] = p.x[3]; q.y[2] = p.y[3]; q.x[3] = p.x[2]; q.y[3] = p.y[2];
    end
    p = q;
    if ($urandom_range(1)) begin
      q.x[0] = p.x[2]; q.y[0] = p.y[2]; q.x[1] = p.x[3]; q.y[1] = p.y[3];
      q.x[2] = p.x[0]; q.y[2] = p.y[0]; q.x[3] = p.x[1]; q.y[3] = p.y[1];
    end
    return q;
  endfunction

  function automatic seg_pair_t gen_random_pair();
    seg_pair_t p;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return gen_collinear_pair();
    for (int k = 0; k < 4; k++) begin
      p.x[k] = COORD_BITS'($urandom);
      p.y[k] = COORD_BITS'($urandom);
      if (pick >= 85) begin
        case ($urandom_range(2))
          0: p.x[k] = '0;
          1: p.x[k] = COORD_BITS'(COORD_MAX);
          default: ;
        endcase
        case ($urandom_range(2))
          0: p.y[k] = '0;
          1: p.y[k] = COORD_BITS'(COORD_MAX);
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_pair(seg_pair_t p);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_x0_i <= p.x[0];
    a_y0_i <= p.y[0];
    a_x1_i <= p.x[1];
    a_y1_i <= p.y[1];
    b_x0_i <= p.x[2];
    b_y0_i <= p.y[2];
    b_x1_i <= p.x[3];
    b_y1_i <= p.y[3];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    merge_expect_q = {merge_expect_q, predict_merge(p)};
  endtask

  task automatic end_stream();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (merge_expect_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (addr)
      REG_MIN_COS:    lim_cos = data[COS_W-1:0];
      REG_MAX_LINE:   lim_line = data[DIST_W-1:0];
      REG_MAX_GAP:    lim_gap = data[DIST_W-1:0];
      REG_MIN_LENGTH: lim_len = data[LEN_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // style 0 realistic, 1 extremes, 2 wide spread; unused high bits random
  task automatic pick_limits(int style);
    logic [CFG_DW-1:0] cos_v, line_v, gap_v, len_v;
    line_v = CFG_DW'($urandom);
    gap_v = CFG_DW'($urandom);
    len_v = CFG_DW'($urandom);
    case (style)
      0: begin
        cos_v = CFG_DW'($urandom_range(29000, 32768));
        line_v[DIST_W-1:0] = DIST_W'($urandom_range(60));
        gap_v[DIST_W-1:0] = DIST_W'($urandom_range(120));
        len_v[LEN_W-1:0] = LEN_W'($urandom_range(24));
      end
      1: begin
        case ($urandom_range(3))
          0: cos_v = '0;
          1: cos_v = CFG_DW'(32768);
          2: cos_v = '1;
          default: cos_v = MIN_COS_RST;
        endcase
        line_v[DIST_W-1:0] = $urandom_range(1) ? '1 : '0;
        gap_v[DIST_W-1:0] = $urandom_range(1) ? '1 : '0;
        len_v[LEN_W-1:0] = $urandom_range(2) == 0 ? '1 : '0;
      end
      default: begin
        cos_v = CFG_DW'($urandom_range(24000, 33000));
        line_v[DIST_W-1:0] = DIST_W'($urandom_range(COORD_MAX));
        gap_v[DIST_W-1:0] = DIST_W'($urandom_range(COORD_MAX));
        len_v[LEN_W-1:0] = LEN_W'($urandom_range(80));
      end
    endcase
    write_reg(REG_MIN_COS, cos_v);
    write_reg(REG_MAX_LINE, line_v);
    write_reg(REG_MAX_GAP, gap_v);
    write_reg(REG_MIN_LENGTH, len_v);
  endtask

  task automatic test_reset_limits();
    send_pair(make_pair(0, 0, 100, 0, 0, 0, 100, 0));
    send_pair(make_pair(10, 10, 110, 10, 130, 10, 230, 10));
    send_pair(make_pair(0, 0, 100, 0, 200, 0, 300, 0));
    send_pair(make_pair(0, 0, 100, 0, 50, 0, 50, 100));
    send_pair(make_pair(0, 0, 100, 0, 0, 40, 100, 40));
    send_pair(make_pair(0, 0, 100, 0, 0, 30, 100, 30));
    send_pair(make_pair(0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0));
    send_pair(make_pair(COORD_MAX, 0, 0, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 100, 0, 50, 0, 50, 0));
    send_pair(make_pair(100, 100, 200, 100, 260, 100, 220, 100));
    send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_pair(make_pair(500, 500, 501, 500, 502, 500, 503, 500));
    end_stream();
  endtask

  task automatic test_zero_length();
    write_reg(REG_MIN_LENGTH, '0);
    send_pair(make_pair(50, 5, 50, 5, 0, 0, 100, 0));
    send_pair(make_pair(0, 0, 100, 0, 50, 0, 50, 0));
    send_pair(make_pair(7, 7, 7, 7, 7, 7, 7, 7));
    end_stream();
    write_reg(REG_MIN_LENGTH, CFG_DW'(MIN_LEN_RST));
  endtask

  task automatic test_cosine_limits();
    write_reg(REG_MIN_COS, '1);
    send_pair(make_pair(0, 0, 100, 0, 0, 0, 100, 0));
    end_stream();
    write_reg(REG_MIN_COS, CFG_DW'(32768));
    send_pair(make_pair(0, 0, 100, 0, 120, 0, 200, 0));
    send_pair(make_pair(0, 0, 100, 0, 120, 0, 220, 1));
    end_stream();
    write_reg(REG_MIN_COS, '0);
    write_reg(REG_MAX_LINE, CFG_DW'(COORD_MAX));
    write_reg(REG_MAX_GAP, CFG_DW'(COORD_MAX));
    send_pair(make_pair(0, 0, 100, 0, 50, 10, 50, 110));
    end_stream();
  endtask

  // high bits beyond each register's width and unused indexes must be ignored
  task automatic test_register_writes();
    write_reg(REG_MIN_COS, CFG_DW'(MIN_COS_RST));
    write_reg(REG_MAX_LINE, 16'hF01E);
    write_reg(REG_MAX_GAP, 16'hF03C);
    write_reg(REG_MIN_LENGTH, 16'hFF01);
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_HI, '0);
    send_pair(make_pair(0, 0, 100, 0, 0, 30, 100, 30));
    send_pair(make_pair(0, 0, 100, 0, 0, 31, 100, 31));
    send_pair(make_pair(0, 0, 100, 0, 160, 0, 260, 0));
    end_stream();
  endtask

  task automatic test_random_stream();
    int send_mode[4];
    int recv_mode[4];
    send_mode = '{0, 75, 0, 16};
    recv_mode = '{0, 0, 75, 16};
    for (int m = 0; m < 4; m++) begin
      for (int style = 0; style < 3; style++) begin
        pick_limits(style);
        send_idle_pct = send_mode[m];
        recv_stall_pct = recv_mode[m];
        repeat (PAIRS_PER_SET) send_pair(gen_random_pair());
        end_stream();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_limits();
    test_zero_length();
    test_cosine_limits();
    test_register_writes();
    test_random_stream();
    wait_drained();
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/csm_pkg.sv
hw/rtl/csm_cfg.sv
hw/rtl/collinear_segment_merge.sv
tb/collinear_segment_merge_test.sv
